@@ design/srb_pkg.sv @@
// Shared types, widths and constants of the scan ring buffer.
package srb_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned VALUE_W  = 20;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PIDX_W   = 11;
	localparam int unsigned ANGLE_W  = 12;
	localparam int unsigned LEN_W    = 11;

	localparam logic [LEN_W-1:0] LEN_RESET = 11'd181;

	localparam int unsigned FULL_ANGLE = 180;
	localparam int unsigned ANGLE_MAX  = FULL_ANGLE * 10;
	localparam int unsigned ANGLE_HALF = ANGLE_MAX / 2;

	// Reciprocal of the angle range, exact for every product the lookup can form.
	localparam int unsigned PROD_W      = LEN_W + ANGLE_W;
	localparam int unsigned RECIP_SHIFT = 34;
	localparam int unsigned RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ANGLE_MAX) - 64'd1) / 64'(ANGLE_MAX));

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_ANGLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_WAIT,
		ST_DIV,
		ST_ISSUE,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

endpackage

@@ design/srb_if.sv @@
// Valid/ready channel interfaces for requests, responses and configuration writes.
interface srb_req_if;
	import srb_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [VALUE_W-1:0] sample_value;
	logic               first_of_scan;
	logic [PIDX_W-1:0]  point_index;
	logic               release_req;
	logic [ANGLE_W-1:0] angle_tenths;

	modport source (output valid, operation, sample_value, first_of_scan, point_index,
		release_req, angle_tenths, input ready);
	modport sink (input valid, operation, sample_value, first_of_scan, point_index,
		release_req, angle_tenths, output ready);
endinterface

interface srb_rsp_if;
	import srb_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [STATUS_W-1:0] status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

interface srb_cfg_if;
	import srb_pkg::*;

	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ design/scan_ring_buffer_with_angle_lookup.sv @@
// Ring of lidar scans that overwrites the oldest scan, with angle lookup in the newest.
//
// Channels: req carries one item per operation (push, read oldest, clear, query at
// angle); rsp returns exactly one item (value, status) for each request, in order;
// cfg writes scan_length and is always ready. Configure only while the block is idle.
// A clear, a push that opens a scan and any request answered with an error status go
// straight to the response stage; an appending push first passes the fill-count read,
// a read the sample and fill-count read, and a query the divide, issue and read stages.
// One request is in work at a time; a new request is taken only once the previous one's
// result is loaded into the output register. The steps follow from the read, modify and
// write of fill counts, the registered sample read and the two-stage rounding lookup.
// The response sits in an output register; while the receiver stalls a new request is
// still accepted and worked, and its result waits until the register frees.
// Reset empties the ring, restores scan_length to 181 and marks every fill count zero
// at once; no clearing pass runs and samples stay undefined until pushed.
module scan_ring_buffer_with_angle_lookup #(
	parameter int unsigned SLOTS      = 8,
	parameter int unsigned MAX_POINTS = 2048
) (
	input  logic  clk,
	input  logic  arst_n,
	srb_req_if.sink   req,
	srb_rsp_if.source rsp,
	srb_cfg_if.sink   cfg
);
	import srb_pkg::*;

	localparam int unsigned SLOT_W = $clog2(SLOTS);
	localparam int unsigned FILL_W = $clog2(MAX_POINTS + 1);
	localparam int unsigned ADDR_W = $clog2(SLOTS * MAX_POINTS);
	localparam int unsigned CMP_W  = (FILL_W > PIDX_W) ? FILL_W : PIDX_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	state_t state_q, state_d;

	logic [SLOT_W-1:0]   oldest_q, oldest_d;
	logic [SLOT_W-1:0]   newest_q, newest_d;
	logic                empty_q, empty_d;
	logic [LEN_W-1:0]    scan_length_q;
	logic [VALUE_W-1:0]  sample_q, sample_d;
	logic [PIDX_W-1:0]   idx_q, idx_d;
	logic [VALUE_W-1:0]  res_value_q, res_value_d;
	status_t             res_status_q, res_status_d;
	logic                rsp_valid_q;
	logic [VALUE_W-1:0]  rsp_value_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic                rsp_load;

	logic                req_acc;
	logic [SLOT_W-1:0]   open_slot;
	logic [LEN_W-1:0]    span;
	logic [LEN_W-1:0]    lookup_idx;

	logic                fill_we;
	logic [SLOT_W-1:0]   fill_waddr;
	logic [FILL_W-1:0]   fill_wdata;
	logic [SLOT_W-1:0]   fill_raddr;
	logic [FILL_W-1:0]   fill_rdata;
	logic                smp_we;
	logic [ADDR_W-1:0]   smp_waddr;
	logic [ADDR_W-1:0]   smp_raddr;
	logic [VALUE_W-1:0]  smp_rdata;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] smp_addr(input logic [SLOT_W-1:0] slot,
			input logic [CMP_W-1:0] idx);
		return ADDR_W'(slot) * ADDR_W'(MAX_POINTS) + ADDR_W'(idx);
	endfunction

	srb_sample_ram #(
		.DEPTH(SLOTS * MAX_POINTS),
		.WIDTH(VALUE_W)
	) u_sample_ram (
		.clk  (clk),
		.we   (smp_we),
		.waddr(smp_waddr),
		.wdata(sample_d),
		.raddr(smp_raddr),
		.rdata(smp_rdata)
	);

	srb_fill_ram #(
		.DEPTH(SLOTS),
		.WIDTH(FILL_W)
	) u_fill_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	assign span = (scan_length_q != '0) ? scan_length_q - LEN_W'(1) : '0;

	srb_angle_index u_angle_index (
		.clk  (clk),
		.load (req_acc),
		.angle(req.angle_tenths),
		.span (span),
		.index(lookup_idx)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign open_slot = next_slot(newest_q);

	assign cfg.ready = 1'b1;

	always_comb begin
		state_d      = state_q;
		oldest_d     = oldest_q;
		newest_d     = newest_q;
		empty_d      = empty_q;
		sample_d     = sample_q;
		idx_d        = idx_q;
		res_value_d  = res_value_q;
		res_status_d = res_status_q;
		rsp_load     = 1'b0;
		fill_we      = 1'b0;
		fill_waddr   = newest_q;
		fill_wdata   = '0;
		fill_raddr   = newest_q;
		smp_we       = 1'b0;
		smp_waddr    = smp_addr(newest_q, '0);
		smp_raddr    = smp_addr(oldest_q, CMP_W'(idx_q));

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					sample_d     = req.sample_value;
					idx_d        = req.point_index;
					res_value_d  = '0;
					res_status_d = STATUS_OK;
					state_d      = ST_DONE;
					unique case (op_t'(req.operation))
						OP_PUSH: begin
							if (req.first_of_scan) begin
								// A new scan starts empty, so its first sample goes in directly unless scan_length is zero.
								newest_d = open_slot;
								if (empty_q) begin
									oldest_d = open_slot;
									empty_d  = 1'b0;
								end else if (open_slot == oldest_q) begin
									oldest_d = next_slot(oldest_q);
								end
								fill_we    = 1'b1;
								fill_waddr = open_slot;
								smp_waddr  = smp_addr(open_slot, '0);
								if (scan_length_q != '0) begin
									fill_wdata = FILL_W'(1);
									smp_we     = 1'b1;
								end
							end else if (empty_q) begin
								res_status_d = STATUS_EMPTY;
							end else begin
								fill_raddr = newest_q;
								state_d    = ST_PUSH_WAIT;
							end
						end
						OP_READ: begin
							if (empty_q) begin
								res_status_d = STATUS_EMPTY;
							end else begin
								fill_raddr = oldest_q;
								smp_raddr  = smp_addr(oldest_q, CMP_W'(req.point_index));
								if (req.release_req) begin
									if (oldest_q == newest_q) begin
										oldest_d = '0;
										newest_d = LAST_SLOT;
										empty_d  = 1'b1;
									end else begin
										oldest_d = next_slot(oldest_q);
									end
								end
								state_d = ST_READ_WAIT;
							end
						end
						OP_CLEAR: begin
							oldest_d = '0;
							newest_d = LAST_SLOT;
							empty_d  = 1'b1;
						end
						OP_QUERY: begin
							if (empty_q) begin
								res_status_d = STATUS_EMPTY;
							end else if (req.angle_tenths > ANGLE_W'(ANGLE_MAX)) begin
								res_status_d = STATUS_ANGLE;
							end else begin
								state_d = ST_DIV;
							end
						end
					endcase
				end
			end
			ST_PUSH_WAIT: begin
				if ((CMP_W'(fill_rdata) < CMP_W'(scan_length_q))
						&& (CMP_W'(fill_rdata) < CMP_W'(MAX_POINTS))) begin
					smp_we     = 1'b1;
					smp_waddr  = smp_addr(newest_q, CMP_W'(fill_rdata));
					fill_we    = 1'b1;
					fill_waddr = newest_q;
					fill_wdata = fill_rdata + FILL_W'(1);
				end
				state_d = ST_DONE;
			end
			ST_DIV: begin
				state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				idx_d      = PIDX_W'(lookup_idx);
				fill_raddr = newest_q;
				smp_raddr  = smp_addr(newest_q, CMP_W'(lookup_idx));
				state_d    = ST_READ_WAIT;
			end
			ST_READ_WAIT: begin
				// Positions at or past the fill count or the scan length read as zero.
				if ((CMP_W'(idx_q) < CMP_W'(fill_rdata)) && (idx_q < scan_length_q)) begin
					res_value_d = smp_rdata;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			oldest_q      <= '0;
			newest_q      <= LAST_SLOT;
			empty_q       <= 1'b1;
			scan_length_q <= LEN_RESET;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			oldest_q <= oldest_d;
			newest_q <= newest_d;
			empty_q  <= empty_d;
			if (cfg.valid && cfg.ready) begin
				scan_length_q <= cfg.data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sample_q     <= sample_d;
		idx_q        <= idx_d;
		res_value_q  <= res_value_d;
		res_status_q <= res_status_d;
		if (rsp_load) begin
			rsp_value_q  <= res_value_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.value  = rsp_value_q;
	assign rsp.status = rsp_status_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (op_t'(req.operation) == OP_CLEAR)) |=> empty_q)
		else $error("ring not empty after a clear item");

	a_empty_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> ((oldest_q == '0) && (newest_q == LAST_SLOT)))
		else $error("empty ring with pointers away from their reset values");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> ((CMP_W'(fill_wdata) <= CMP_W'(MAX_POINTS))
			&& (CMP_W'(fill_wdata) <= CMP_W'(scan_length_q))))
		else $error("fill count written beyond the scan length");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req.ready)
		else $error("second item accepted while one is in work");

endmodule

@@ design/srb_sample_ram.sv @@
// Single-port-write, single-port-read sample memory with a registered read.
module srb_sample_ram #(
	parameter int unsigned DEPTH = 16384,
	parameter int unsigned WIDTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/srb_fill_ram.sv @@
// Per-slot fill-count memory; entries read as zero until first written after reset.
module srb_fill_ram #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

@@ design/srb_angle_index.sv @@
// Two-stage unit that maps an angle to the nearest sample index of a scan.
module srb_angle_index (
	input  logic                        clk,
	input  logic                        load,
	input  logic [srb_pkg::ANGLE_W-1:0] angle,
	input  logic [srb_pkg::LEN_W-1:0]   span,
	output logic [srb_pkg::LEN_W-1:0]   index
);
	import srb_pkg::*;

	localparam int unsigned SCALED_W = PROD_W + RECIP_W;

	logic [PROD_W-1:0]   prod_s1;
	logic [PROD_W-1:0]   biased;
	logic [SCALED_W-1:0] scaled;
	logic [LEN_W-1:0]    index_s2;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(span) * PROD_W'(angle);
		end
	end

	// Adding half the range before the reciprocal multiply rounds halves up.
	assign biased = prod_s1 + PROD_W'(ANGLE_HALF);
	assign scaled = SCALED_W'(biased) * SCALED_W'(RECIP);

	always_ff @(posedge clk) begin
		index_s2 <= scaled[RECIP_SHIFT +: LEN_W];
	end

	assign index = index_s2;

endmodule
